// File: hw/rtl/sliding_window_mean_stddev_top_macros.svh
// ----------------------------------------------------------------------------
// Sliding window statistics assertion macros
// Shared property macros for the checker of the statistics block.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEAN_STDDEV_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEAN_STDDEV_TOP_MACROS_SVH

// Implication checked outside reset.
`define SWMS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked at every edge, reset included.
`define SWMS_ASSERT_NXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/swms_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window statistics package
// Fixed field widths, step counts and operation codes.
// ----------------------------------------------------------------------------
package swms_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int WS_W      = 7;
   localparam int MEAN_W    = 24;
   localparam int DEV_W     = 24;
   localparam int COUNT_W   = 7;
   localparam int QUO_W     = 48;
   localparam int STEP_W    = 6;
   localparam int FRAC_W    = 16;
   localparam int MFRAC_W   = 8;
   localparam int SQ_W      = 32;
   localparam int ROOT_W    = 24;
   localparam int SREM_W    = 28;

   localparam logic [WS_W-1:0] WS_RESET = 7'd64;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

endpackage

// File: hw/rtl/sliding_window_mean_stddev_top.sv
// ----------------------------------------------------------------------------
// Sliding window mean and standard deviation
// Moving-window mean and sample standard deviation of 16-bit samples.
// ----------------------------------------------------------------------------
// Requests arrive on req_: tuser is the operation (add or clear), tdata the
// signed sample. Every request yields exactly one response on rsp_ with the
// window mean (signed Q16.8), the sample deviation (Q16.8), a deviation
// valid flag and the sample count.
// The window size register is written on csr_; the user must do so only while
// the block is idle, which the block itself does not enforce. The front end
// handles each request in its idle and check states, plus a retire and a check
// state per sample that leaves the window when it is full or shrinks. The back
// end steps through a multiply state, a setup state, a 48-step restoring
// division (the mean division runs in its first 24 steps), a 24-step square
// root and the output state; a clear skips to output. The back end sets
// the throughput; the two-entry queue and the output register let front and
// back run on their own. Reset empties the window and sets the window size
// to 64. When the receiver stalls, the response holds in the output
// register, the back end and then the queue fill, and req_tready drops.
// ----------------------------------------------------------------------------
module sliding_window_mean_stddev_top import swms_pkg::*; #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,  // sample
   input  logic                  req_tuser,  // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // mean, deviation, deviation_valid, sample_count
   output logic [MEAN_W+DEV_W+1+COUNT_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WS_W-1:0]       csr_data
);

   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int SW = SAMPLE_W + CW;
   localparam int QW = 2 * (SAMPLE_W - 1) + CW;
   localparam int EW = 1 + CW + SW + QW;

   logic [WS_W-1:0] win_size_ff;
   logic            q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   logic [EW-1:0]   q_in_data, q_out_data;
   op_type          req_op;

   assign csr_ready = 1'b1;
   assign req_op    = op_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= WS_RESET;
      end else if (csr_valid && csr_ready) begin
         win_size_ff <= csr_data;
      end
   end

   swms_front #(.WINDOW_MAX(WINDOW_MAX), .CW(CW), .SW(SW), .QW(QW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_op),
      .req_sample (req_tdata),
      .win_size   (win_size_ff),
      .push_valid (q_in_valid),
      .push_ready (q_in_ready),
      .push_data  (q_in_data)
   );

   swms_fifo #(.WIDTH(EW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   swms_back #(.CW(CW), .SW(SW), .QW(QW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_out_valid),
      .pop_ready (q_out_ready),
      .pop_data  (q_out_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule

// File: hw/rtl/swms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/swms_front.sv
// ----------------------------------------------------------------------------
// Sliding window front end
// Accepts requests, keeps the sample ring and the running sums.
// ----------------------------------------------------------------------------
module swms_front import swms_pkg::*; #(
   parameter int WINDOW_MAX = 64,
   parameter int CW         = 7,
   parameter int SW         = 23,
   parameter int QW         = 37
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  op_type                 req_op,
   input  logic [SAMPLE_W-1:0]    req_sample,
   input  logic [WS_W-1:0]        win_size,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [1+CW+SW+QW-1:0]  push_data
);

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int LW = (CW > WS_W) ? CW : WS_W;

   typedef enum logic [2:0] {
      F_IDLE   = 3'b001,
      F_CHECK  = 3'b010,
      F_RETIRE = 3'b100
   } fstate_type;

   fstate_type                 state_ff, state_in;
   op_type                     op_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [AW-1:0]              ptr_ff, ptr_in;
   logic [CW-1:0]              count_ff, count_in;
   logic signed [SW-1:0]       sum_ff, sum_in;
   logic [QW-1:0]              sumsq_ff, sumsq_in;
   logic [CW-1:0]              limit;
   logic                       need_retire;
   logic [AW:0]                slot_sum;
   logic [AW-1:0]              slot;
   logic [SAMPLE_W-1:0]        rd_data;
   logic signed [SAMPLE_W-1:0] mul_in;
   logic signed [SQ_W-1:0]     square;
   logic                       wr_en;
   logic                       clr_out;

   always_comb begin
      if (win_size == '0) begin
         limit = CW'(1);
      end else if (LW'(win_size) > LW'(WINDOW_MAX)) begin
         limit = CW'(WINDOW_MAX);
      end else begin
         limit = CW'(win_size);
      end
   end

   assign need_retire = (count_ff >= limit) && (count_ff != '0);
   assign slot_sum    = (AW+1)'(ptr_ff) + (AW+1)'(count_ff);
   assign slot        = (slot_sum >= (AW+1)'(WINDOW_MAX)) ?
                        AW'(slot_sum - (AW+1)'(WINDOW_MAX)) : AW'(slot_sum);
   assign mul_in      = (state_ff == F_RETIRE) ? $signed(rd_data) : sample_ff;
   assign square      = mul_in * mul_in;

   swms_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (sample_ff),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      sumsq_in   = sumsq_ff;
      wr_en      = 1'b0;
      push_valid = 1'b0;
      clr_out    = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = F_CHECK;
            end
         end
         F_CHECK: begin
            if (op_ff == OP_CLEAR) begin
               push_valid = 1'b1;
               clr_out    = 1'b1;
               if (push_ready) begin
                  ptr_in   = '0;
                  count_in = '0;
                  sum_in   = '0;
                  sumsq_in = '0;
                  state_in = F_IDLE;
               end
            end else if (need_retire) begin
               state_in = F_RETIRE;
            end else begin
               push_valid = 1'b1;
               count_in   = count_ff + CW'(1);
               sum_in     = sum_ff + SW'(sample_ff);
               sumsq_in   = sumsq_ff + QW'($unsigned(square));
               if (push_ready) begin
                  wr_en    = 1'b1;
                  state_in = F_IDLE;
               end
            end
         end
         F_RETIRE: begin
            sum_in   = sum_ff - SW'($signed(rd_data));
            sumsq_in = sumsq_ff - QW'($unsigned(square));
            ptr_in   = (ptr_ff == AW'(WINDOW_MAX - 1)) ? '0 : ptr_ff + AW'(1);
            count_in = count_ff - CW'(1);
            state_in = F_CHECK;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == F_IDLE);
   assign push_data = {clr_out, count_in, sum_in, sumsq_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         ptr_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff != F_CHECK) || !push_valid || push_ready) begin
            ptr_ff   <= ptr_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
            sumsq_ff <= sumsq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff     <= req_op;
         sample_ff <= $signed(req_sample);
      end
   end

endmodule

// File: hw/rtl/swms_fifo.sv
// ----------------------------------------------------------------------------
// Two-entry queue
// Decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module swms_fifo #(
   parameter int WIDTH = 68
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff;
   logic             rd_ff;
   logic [1:0]       cnt_ff;
   logic             do_wr;
   logic             do_rd;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign do_wr     = in_valid && in_ready;
   assign do_rd     = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_wr) begin
            wr_ff <= ~wr_ff;
         end
         if (do_rd) begin
            rd_ff <= ~rd_ff;
         end
         if (do_wr && !do_rd) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (do_rd && !do_wr) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule

// File: hw/rtl/swms_back.sv
// ----------------------------------------------------------------------------
// Sliding window back end
// Computes mean and deviation by serial division and square root.
// ----------------------------------------------------------------------------
module swms_back import swms_pkg::*; #(
   parameter int CW = 7,
   parameter int SW = 23,
   parameter int QW = 37
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   pop_valid,
   output logic                                   pop_ready,
   input  logic [1+CW+SW+QW-1:0]                  pop_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [MEAN_W+DEV_W+1+COUNT_W-1:0]      rsp_data
);

   localparam int NW = QW + CW;
   localparam int PW = 2 * SW;
   localparam int XW = ((NW > PW) ? NW : PW) + 1;
   localparam int DW = 2 * CW;

   typedef enum logic [5:0] {
      B_IDLE = 6'b000001,
      B_MUL  = 6'b000010,
      B_PREP = 6'b000100,
      B_DIV  = 6'b001000,
      B_SQRT = 6'b010000,
      B_OUT  = 6'b100000
   } bstate_type;

   bstate_type               state_ff, state_in;
   logic                     clr;
   logic [CW-1:0]            pop_n;
   logic signed [SW-1:0]     pop_sum;
   logic [QW-1:0]            pop_sumsq;
   logic [CW-1:0]            n_ff;
   logic signed [SW-1:0]     sum_ff;
   logic [QW-1:0]            sumsq_ff;
   logic [NW-1:0]            prod1_ff;
   logic signed [PW-1:0]     prod2_ff;
   logic [DW-1:0]            den_ff;
   logic [DW-1:0]            drem_ff;
   logic [QUO_W-1:0]         dbits_ff;
   logic [QUO_W-1:0]         quo_ff;
   logic [CW-1:0]            mrem_ff;
   logic [MEAN_W-1:0]        mbits_ff;
   logic [MEAN_W-1:0]        mquo_ff;
   logic                     neg_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [SREM_W-1:0]        srem_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [QUO_W-1:0]         sx_ff;
   logic                     rsp_valid_ff;
   logic [MEAN_W+DEV_W+1+COUNT_W-1:0] rsp_data_ff;
   logic [XW-1:0]            num_x;
   logic [XW-1:0]            num;
   logic [SW-1:0]            abs_sum;
   logic [DW:0]              dtrial;
   logic                     dbit;
   logic [DW-1:0]            drem_nx;
   logic [CW:0]              mtrial;
   logic                     mbit;
   logic [CW-1:0]            mrem_nx;
   logic [SREM_W-1:0]        strial;
   logic [SREM_W-1:0]        sdiv;
   logic                     sbit;
   logic [MEAN_W-1:0]        mean_val;
   logic                     dev_ok;
   logic                     load_out;

   assign {clr, pop_n, pop_sum, pop_sumsq} = pop_data;

   assign num_x   = XW'(prod1_ff) - XW'($unsigned(prod2_ff));
   assign num     = num_x[XW-1] ? '0 : num_x;
   assign abs_sum = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);

   assign dtrial  = {drem_ff, dbits_ff[QUO_W-1]};
   assign dbit    = (dtrial >= (DW+1)'(den_ff));
   assign drem_nx = dbit ? DW'(dtrial - (DW+1)'(den_ff)) : DW'(dtrial);

   assign mtrial  = {mrem_ff, mbits_ff[MEAN_W-1]};
   assign mbit    = (mtrial >= (CW+1)'(n_ff));
   assign mrem_nx = mbit ? CW'(mtrial - (CW+1)'(n_ff)) : CW'(mtrial);

   assign strial  = {srem_ff[SREM_W-3:0], sx_ff[QUO_W-1:QUO_W-2]};
   assign sdiv    = {(SREM_W-2)'(root_ff), 2'b01};
   assign sbit    = (strial >= sdiv);

   assign dev_ok   = (n_ff >= CW'(2));
   assign mean_val = neg_ff ? MEAN_W'(-mquo_ff) : mquo_ff;
   assign load_out = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               state_in = clr ? B_OUT : B_MUL;
            end
         end
         B_MUL: begin
            state_in = B_PREP;
         end
         B_PREP: begin
            state_in = B_DIV;
         end
         B_DIV: begin
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = B_SQRT;
            end
         end
         B_SQRT: begin
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (load_out) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign pop_ready = (state_ff == B_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               n_ff     <= pop_n;
               sum_ff   <= pop_sum;
               sumsq_ff <= pop_sumsq;
               mquo_ff  <= '0;
               neg_ff   <= 1'b0;
               root_ff  <= '0;
            end
         end
         B_MUL: begin
            prod1_ff <= NW'(n_ff) * NW'(sumsq_ff);
            prod2_ff <= PW'(sum_ff) * PW'(sum_ff);
            den_ff   <= DW'(n_ff) * (DW'(n_ff) - DW'(1));
         end
         B_PREP: begin
            drem_ff  <= DW'(num >> (QUO_W - FRAC_W));
            dbits_ff <= {num[QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            mrem_ff  <= CW'(abs_sum >> (MEAN_W - MFRAC_W));
            mbits_ff <= {abs_sum[MEAN_W-MFRAC_W-1:0], {MFRAC_W{1'b0}}};
            neg_ff   <= sum_ff[SW-1];
            step_ff  <= '0;
         end
         B_DIV: begin
            drem_ff  <= drem_nx;
            dbits_ff <= {dbits_ff[QUO_W-2:0], 1'b0};
            quo_ff   <= {quo_ff[QUO_W-2:0], dbit};
            if (step_ff < STEP_W'(MEAN_W)) begin
               mrem_ff  <= mrem_nx;
               mbits_ff <= {mbits_ff[MEAN_W-2:0], 1'b0};
               mquo_ff  <= {mquo_ff[MEAN_W-2:0], mbit};
            end
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               sx_ff   <= {quo_ff[QUO_W-2:0], dbit};
               srem_ff <= '0;
               root_ff <= '0;
               step_ff <= '0;
            end else begin
               step_ff <= step_ff + STEP_W'(1);
            end
         end
         B_SQRT: begin
            sx_ff   <= {sx_ff[QUO_W-3:0], 2'b00};
            srem_ff <= sbit ? (strial - sdiv) : strial;
            root_ff <= {root_ff[ROOT_W-2:0], sbit};
            step_ff <= step_ff + STEP_W'(1);
         end
         B_OUT: begin
            if (load_out) begin
               rsp_data_ff <= {COUNT_W'(n_ff), dev_ok,
                               dev_ok ? root_ff : {DEV_W{1'b0}}, mean_val};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/swms_checker.sv
// ----------------------------------------------------------------------------
// Sliding window statistics checker
// Port-level properties of the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_mean_stddev_top_macros.svh"

module swms_checker import swms_pkg::*; (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [MEAN_W+DEV_W+1+COUNT_W-1:0]   rsp_tdata
);

   logic [MEAN_W-1:0]  mean;
   logic [DEV_W-1:0]   dev;
   logic               dev_ok;
   logic [COUNT_W-1:0] count;

   assign {count, dev_ok, dev, mean} = rsp_tdata;

   `SWMS_ASSERT_NXT(a_reset_idle, clock, reset, !rsp_tvalid)
   `SWMS_ASSERT_IMP(a_hold, clock, reset, $past(rsp_tvalid && !rsp_tready) && !$past(reset), rsp_tvalid && $stable(rsp_tdata))
   `SWMS_ASSERT_IMP(a_dev_flag, clock, reset, rsp_tvalid, dev_ok == (count >= COUNT_W'(2)))
   `SWMS_ASSERT_IMP(a_empty, clock, reset, rsp_tvalid && (count == '0), (mean == '0) && (dev == '0))

endmodule

bind sliding_window_mean_stddev_top swms_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
